// ===== hdl/dotl_pkg.sv =====
`default_nettype none
package dotl_pkg;

  // list size and derived widths
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int OP_W  = 2;
  localparam int DL_W  = 23;
  localparam int ID_W  = 16;
  localparam int ST_W  = 3;
  localparam int NID_W = ID_W + 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOIDS    = 3'd4;

  // where the id and deadline of a result come from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_NEWID,
    SRC_DELID,
    SRC_SLOT
  } src_e;

  // controller to datapath
  typedef struct packed {
    logic             capture;
    logic             commit_add;
    logic             commit_del;
    logic             load_out;
    logic [ST_W-1:0]  status;
    src_e             src;
    logic             last;
    logic [IDX_W-1:0] list_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             full;
    logic             exhausted;
    logic             empty;
    logic             found;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/dotl_in_if.sv =====
`default_nettype none
interface dotl_in_if;
  import dotl_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [DL_W-1:0] deadline_key;
  logic [ID_W-1:0] task_id;

  modport source (output valid, output operation, output deadline_key, output task_id,
                  input ready);
  modport sink   (input valid, input operation, input deadline_key, input task_id,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/dotl_out_if.sv =====
`default_nettype none
interface dotl_out_if;
  import dotl_pkg::*;

  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;
  logic [ID_W-1:0] entry_id;
  logic [DL_W-1:0] entry_deadline;
  logic            last;

  modport source (output valid, output status, output entry_id, output entry_deadline,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_id, input entry_deadline,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/dotl_ctrl.sv =====
`default_nettype none
module dotl_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [dotl_pkg::OP_W-1:0] in_op_i,
  output logic                           in_ready_o,
  input  wire dotl_pkg::sts_t            sts_i,
  output dotl_pkg::cmd_t                 cmd_o
);
  import dotl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RESP = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;
  logic             list_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign list_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == sts_i.count);

  // sequencing and result selection
  always_comb begin
    state_d            = state_q;
    op_d               = op_q;
    idx_d              = idx_q;
    cmd_o              = '0;
    cmd_o.src          = SRC_NONE;
    cmd_o.capture      = accept;
    cmd_o.list_idx     = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = in_op_i;
          if (in_op_i inside {OP_ADD, OP_DEL, OP_LIST}) state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
          case (op_q)
            OP_ADD: begin
              cmd_o.load_out = 1'b1;
              if (sts_i.full) begin
                cmd_o.status = ST_FULL;
              end else if (sts_i.exhausted) begin
                cmd_o.status = ST_NOIDS;
              end else begin
                cmd_o.status     = ST_OK;
                cmd_o.src        = SRC_NEWID;
                cmd_o.commit_add = 1'b1;
              end
            end
            OP_DEL: begin
              cmd_o.load_out = 1'b1;
              if (sts_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else if (!sts_i.found) begin
                cmd_o.status = ST_NOTFOUND;
              end else begin
                cmd_o.status     = ST_OK;
                cmd_o.src        = SRC_DELID;
                cmd_o.commit_del = 1'b1;
              end
            end
            OP_LIST: begin
              if (sts_i.empty) begin
                cmd_o.load_out = 1'b1;
                cmd_o.status   = ST_EMPTY;
              end else begin
                cmd_o.last = 1'b0;
                idx_d      = '0;
                state_d    = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        // one entry per cycle while the output register drains
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.status   = ST_OK;
          cmd_o.src      = SRC_SLOT;
          cmd_o.last     = list_last;
          if (list_last) state_d = S_IDLE;
          else idx_d = idx_q + IDX_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    idx_q <= idx_d;
  end

endmodule
`default_nettype wire

// ===== hdl/dotl_cells.sv =====
`default_nettype none
module dotl_cells (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [dotl_pkg::DL_W-1:0] in_key_i,
  input  wire logic [dotl_pkg::ID_W-1:0] in_id_i,
  input  wire dotl_pkg::cmd_t            cmd_i,
  output dotl_pkg::sts_t                 sts_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [dotl_pkg::ST_W-1:0]      out_status_o,
  output logic [dotl_pkg::ID_W-1:0]      out_id_o,
  output logic [dotl_pkg::DL_W-1:0]      out_dl_o,
  output logic                           out_last_o
);
  import dotl_pkg::*;

  logic [ID_W-1:0]  slot_id_q [CAPACITY];
  logic [DL_W-1:0]  slot_dl_q [CAPACITY];
  logic [CNT_W-1:0] count_q;
  logic [NID_W-1:0] next_id_q;
  logic [DL_W-1:0]  key_q;
  logic [ID_W-1:0]  tid_q;
  logic [CAPACITY-1:0] le_d, le_q, seen_d, seen_q, match, ins;
  logic             out_valid_q;
  logic [ST_W-1:0]  out_status_q;
  logic [ID_W-1:0]  out_id_q;
  logic [DL_W-1:0]  out_dl_q;
  logic             out_last_q;

  // per-cell compares against the incoming item
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le_d[i]  = (CNT_W'(i) < count_q) && (slot_dl_q[i] <= in_key_i);
      match[i] = (CNT_W'(i) < count_q) && (slot_id_q[i] == in_id_i);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      seen_d[i] = |(match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
    end
  end

  // insertion point is the first cell past the equal-or-earlier prefix
  assign ins = ~le_q & {le_q[CAPACITY-2:0], 1'b1};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      le_q   <= le_d;
      seen_q <= seen_d;
      key_q  <= in_key_i;
      tid_q  <= in_id_i;
    end
  end

  // cell chain: shift toward the tail on add, toward the head on delete
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_W-1:0] up_id, dn_id;
    logic [DL_W-1:0] up_dl, dn_dl;
    if (g == 0) begin : g_head
      assign up_id = next_id_q[ID_W-1:0];
      assign up_dl = key_q;
    end else begin : g_body
      assign up_id = slot_id_q[g-1];
      assign up_dl = slot_dl_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign dn_id = slot_id_q[g];
      assign dn_dl = slot_dl_q[g];
    end else begin : g_inner
      assign dn_id = slot_id_q[g+1];
      assign dn_dl = slot_dl_q[g+1];
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.commit_add) begin
        if (ins[g]) begin
          slot_id_q[g] <= next_id_q[ID_W-1:0];
          slot_dl_q[g] <= key_q;
        end else if (!le_q[g]) begin
          slot_id_q[g] <= up_id;
          slot_dl_q[g] <= up_dl;
        end
      end else if (cmd_i.commit_del && seen_q[g]) begin
        slot_id_q[g] <= dn_id;
        slot_dl_q[g] <= dn_dl;
      end
    end
  end

  // fill count and id counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      next_id_q <= NID_W'(1);
    end else if (cmd_i.commit_add) begin
      count_q   <= count_q + CNT_W'(1);
      next_id_q <= next_id_q + NID_W'(1);
    end else if (cmd_i.commit_del) begin
      count_q   <= count_q - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.status;
      out_last_q   <= cmd_i.last;
      out_dl_q     <= '0;
      case (cmd_i.src)
        SRC_NEWID: out_id_q <= next_id_q[ID_W-1:0];
        SRC_DELID: out_id_q <= tid_q;
        SRC_SLOT: begin
          out_id_q <= slot_id_q[cmd_i.list_idx];
          out_dl_q <= slot_dl_q[cmd_i.list_idx];
        end
        default: out_id_q <= '0;
      endcase
    end
  end

  assign sts_o.full      = (count_q == CNT_W'(CAPACITY));
  assign sts_o.exhausted = next_id_q[NID_W-1];
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.found     = seen_q[CAPACITY-1];
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.count     = count_q;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_dl_o     = out_dl_q;
  assign out_last_o   = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/deadline_ordered_task_list.sv =====
// channel | dir | handshake   | payload
// in_i    | in  | valid/ready | operation, deadline_key, task_id
// out_o   | out | valid/ready | status, entry_id, entry_deadline, last
//
// add and delete: compare of every cell at accept, then the chain shifts in
// one step as the result is loaded into the output register.
// a list: the accept cycle, a turn cycle, then one entry per cycle
// paced by the output register; next item after that.
// reset (rst_ni low, asynchronous) empties the list and sets the id counter
// to one; cell contents are not cleared. a stalled output holds the block.
`default_nettype none
module deadline_ordered_task_list (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dotl_in_if.sink   in_i,
  dotl_out_if.source out_o
);
  import dotl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dotl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dotl_cells u_cells (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_key_i     (in_i.deadline_key),
    .in_id_i      (in_i.task_id),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_id_o     (out_o.entry_id),
    .out_dl_o     (out_o.entry_deadline),
    .out_last_o   (out_o.last)
  );

endmodule
`default_nettype wire

// ===== hdl/dotl_checker.sv =====
`default_nettype none
module dotl_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic [dotl_pkg::OP_W-1:0] in_op_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [dotl_pkg::ST_W-1:0] out_status_i,
  input wire logic [dotl_pkg::ID_W-1:0] out_id_i,
  input wire logic [dotl_pkg::DL_W-1:0] out_dl_i,
  input wire logic                      out_last_i
);
  import dotl_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_id_i) && $stable(out_dl_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // an error result is single and carries no entry
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_last_i && (out_id_i == '0)
      && (out_dl_i == '0))
    else $error("error result with payload or without last");

  // a real operation keeps the input closed on the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OP_ADD || in_op_i == OP_DEL
      || in_op_i == OP_LIST) |=> !in_ready_i)
    else $error("input open right after an operation");

  // mid-list: input closed and the next entry follows at once
  a_list_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i ##1 out_valid_i)
    else $error("list broken off");

endmodule

bind deadline_ordered_task_list dotl_checker u_dotl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.operation),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_id_i     (out_o.entry_id),
  .out_dl_i     (out_o.entry_deadline),
  .out_last_i   (out_o.last)
);
`default_nettype wire
